// ----- rtl/tccc_pkg.sv -----
// shared types, codes and helpers of the text console cursor controller
package tccc_pkg;

    localparam logic [2:0] OP_INVERT      = 3'd0;
    localparam logic [2:0] OP_DRAW        = 3'd1;
    localparam logic [2:0] OP_SCROLL_UP   = 3'd2;
    localparam logic [2:0] OP_SCROLL_DOWN = 3'd3;
    localparam logic [2:0] OP_CLEAR       = 3'd4;
    localparam logic [2:0] OP_NONE        = 3'd5;

    localparam logic [6:0] CH_BACKSPACE = 7'o010;
    localparam logic [6:0] CH_LINE_FEED = 7'o012;
    localparam logic [6:0] CH_UP        = 7'o013;
    localparam logic [6:0] CH_RIGHT     = 7'o014;
    localparam logic [6:0] CH_RETURN    = 7'o015;
    localparam logic [6:0] CH_RSCROLL   = 7'o022;
    localparam logic [6:0] CH_DEL_LINE  = 7'o030;
    localparam logic [6:0] CH_CLEAR     = 7'o032;
    localparam logic [6:0] CH_SPACE     = 7'o040;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS           = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_PRESENT = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    localparam int CMDS_PER_JOB = 4;
    localparam int CMD_IDX_W    = 2;

    typedef struct packed {
        logic [6:0] top;
        logic [6:0] glyph;
        logic [6:0] row;
        logic [7:0] col;
        logic [2:0] op;
    } cmd_t;

    typedef struct packed {
        logic [CMD_IDX_W-1:0]          last_idx;
        cmd_t [CMDS_PER_JOB-1:0]       cmd;
    } job_t;

    typedef struct packed {
        logic [7:0] columns;
        logic [6:0] rows;
        logic       screen_present;
    } cfg_t;

    function automatic cmd_t mk_cmd(logic [2:0] op, logic [7:0] col, logic [6:0] row,
                                    logic [6:0] glyph, logic [6:0] top);
        cmd_t c;
        c.op    = op;
        c.col   = col;
        c.row   = row;
        c.glyph = glyph;
        c.top   = top;
        return c;
    endfunction

endpackage

// ----- rtl/tccc_front.sv -----
// front end: decodes a character, moves the cursor and builds its command run
module tccc_front
    import tccc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    input  logic [7:0] in_char,
    output logic       in_ready,
    input  logic       queue_full,
    output logic       push,
    output job_t       push_job
);

    logic [7:0] cursor_col_reg, cursor_col_next;
    logic [6:0] cursor_row_reg, cursor_row_next;

    logic [6:0] c;
    logic [7:0] ncols;
    logic [6:0] nrows;
    logic [8:0] col_inc;
    logic [7:0] row_inc;
    logic       ld_wrap;
    logic [6:0] ld_row;
    cmd_t       mid0, mid1, fin;
    logic [1:0] mid_n;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    assign c       = in_char[6:0];
    assign ncols   = (cfg.columns == 8'd0) ? 8'd1 : cfg.columns;
    assign nrows   = (cfg.rows == 7'd0) ? 7'd1 : cfg.rows;
    assign col_inc = {1'b0, cursor_col_reg} + 9'd1;
    assign row_inc = {1'b0, cursor_row_reg} + 8'd1;
    assign ld_wrap = row_inc >= {1'b0, nrows};
    assign ld_row  = ld_wrap ? (nrows - 7'd1) : row_inc[6:0];

    always_comb
    begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        mid0  = '0;
        mid1  = '0;
        mid_n = 2'd0;
        unique case (c)
            CH_BACKSPACE:
            begin
                if (cursor_col_reg != 8'd0)
                    cursor_col_next = cursor_col_reg - 8'd1;
                mid0  = mk_cmd(OP_DRAW, cursor_col_next, cursor_row_reg, CH_SPACE, 7'd0);
                mid_n = 2'd1;
            end
            CH_RETURN:
            begin
                cursor_col_next = 8'd0;
            end
            CH_LINE_FEED:
            begin
                cursor_row_next = ld_row;
                mid0  = mk_cmd(OP_SCROLL_UP, 8'd0, 7'd0, 7'd0, 7'd0);
                mid_n = ld_wrap ? 2'd1 : 2'd0;
            end
            CH_UP:
            begin
                if (cursor_row_reg != 7'd0)
                    cursor_row_next = cursor_row_reg - 7'd1;
            end
            CH_RIGHT:
            begin
                if (col_inc < {1'b0, ncols})
                    cursor_col_next = col_inc[7:0];
            end
            CH_CLEAR:
            begin
                cursor_col_next = 8'd0;
                cursor_row_next = 7'd0;
                mid0  = mk_cmd(OP_CLEAR, 8'd0, 7'd0, 7'd0, 7'd0);
                mid1  = mk_cmd(OP_INVERT, 8'd0, 7'd0, 7'd0, 7'd0);
                mid_n = 2'd2;
            end
            CH_RSCROLL:
            begin
                if (cursor_row_reg != 7'd0)
                begin
                    cursor_row_next = cursor_row_reg - 7'd1;
                end
                else
                begin
                    mid0  = mk_cmd(OP_SCROLL_DOWN, 8'd0, 7'd0, 7'd0, 7'd0);
                    mid_n = 2'd1;
                end
            end
            CH_DEL_LINE:
            begin
                mid0  = mk_cmd(OP_SCROLL_UP, 8'd0, 7'd0, 7'd0, cursor_row_reg);
                mid_n = 2'd1;
            end
            default:
            begin
                mid0 = mk_cmd(OP_DRAW, cursor_col_reg, cursor_row_reg, c, 7'd0);
                mid1 = mk_cmd(OP_SCROLL_UP, 8'd0, 7'd0, 7'd0, 7'd0);
                if (col_inc >= {1'b0, ncols})
                begin
                    cursor_col_next = 8'd0;
                    cursor_row_next = ld_row;
                    mid_n = ld_wrap ? 2'd2 : 2'd1;
                end
                else
                begin
                    cursor_col_next = col_inc[7:0];
                    mid_n = 2'd1;
                end
            end
        endcase
    end

    assign fin = mk_cmd(OP_INVERT, cursor_col_next, cursor_row_next, 7'd0, 7'd0);

    always_comb
    begin
        push_job = '0;
        if (!cfg.screen_present)
        begin
            push_job.cmd[0]   = mk_cmd(OP_NONE, 8'd0, 7'd0, 7'd0, 7'd0);
            push_job.last_idx = '0;
        end
        else
        begin
            push_job.cmd[0] = mk_cmd(OP_INVERT, cursor_col_reg, cursor_row_reg, 7'd0, 7'd0);
            push_job.cmd[1] = (mid_n != 2'd0) ? mid0 : fin;
            push_job.cmd[2] = (mid_n == 2'd2) ? mid1 : fin;
            push_job.cmd[3] = fin;
            push_job.last_idx = mid_n + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
        end
        else if (push && cfg.screen_present)
        begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
        end
    end

endmodule

// ----- rtl/tccc_queue.sv -----
// short job queue between the decoder and the command sequencer
module tccc_queue
    import tccc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    output logic head_valid,
    output job_t head_job,
    input  logic pop
);

    job_t                   mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    assign full       = count_reg == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/tccc_back.sv -----
// back end: steps through a queued run and issues one command per cycle while the output is not stalled
module tccc_back
    import tccc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  job_t        head_job,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output cmd_t        out_cmd,
    output logic        out_last
);

    logic [CMD_IDX_W-1:0] idx_reg;
    logic                 valid_reg;
    cmd_t                 cmd_reg;
    logic                 last_reg;
    logic                 load;
    logic                 at_last;

    assign load      = head_valid && (!valid_reg || out_ready);
    assign at_last   = idx_reg == head_job.last_idx;
    assign pop       = load && at_last;
    assign out_valid = valid_reg;
    assign out_cmd   = cmd_reg;
    assign out_last  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= at_last ? '0 : idx_reg + 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg  <= head_job.cmd[idx_reg];
            last_reg <= at_last;
        end
    end

endmodule

// ----- rtl/text_console_cursor_controller.sv -----
// top level of the text console cursor controller
//
// usage: each request on the s_axis side carries one character byte (bit 7
// is ignored). for each character the block emits a run of one to four
// display commands on the m_axis side, tlast marking the final one. a run is
// normally invert old cursor cell, the character's own commands, invert new
// cursor cell; with no screen present the run is a single no-op command.
// configuration (columns, rows, screen_present) is to be written by the user through cfg_we,
// cfg_index and cfg_wdata only while the block is idle; the block itself does not enforce
// this. other indexes are ignored. an accepted character is written into the queue, and
// its first command is then loaded from the queue head into the output register.
// throughput: one command per cycle while m_axis is ready, set by the sequencer that
// issues a run from the two-entry queue; the decoder takes a character per cycle while
// the queue has room.
// a stalled m_axis holds its command in the output register; the queue then
// fills and s_axis_tready drops.
// reset clears the cursor to (0,0), empties the queue and restores
// columns 80, rows 25, no screen.
module text_console_cursor_controller
    import tccc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // char_in[7:0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,   // op[2:0] cell_col[10:3] cell_row[17:11]
                                                 // glyph[24:18] region_top[31:25]
    output logic                 m_axis_tlast,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_wdata
);

    cfg_t cfg_reg;
    logic queue_full;
    logic push;
    job_t push_job;
    logic head_valid;
    job_t head_job;
    logic pop;
    cmd_t out_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.columns        <= 8'd80;
            cfg_reg.rows           <= 7'd25;
            cfg_reg.screen_present <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COLUMNS:        cfg_reg.columns        <= cfg_wdata;
                REG_ROWS:           cfg_reg.rows           <= cfg_wdata[6:0];
                REG_SCREEN_PRESENT: cfg_reg.screen_present <= cfg_wdata[0];
                default:            ;
            endcase
        end
    end

    tccc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_axis_tvalid),
        .in_char    (s_axis_tdata),
        .in_ready   (s_axis_tready),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    tccc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop)
    );

    tccc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_cmd    (out_cmd),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {out_cmd.top, out_cmd.glyph, out_cmd.row, out_cmd.col, out_cmd.op};

    // a no-op command is always a run of its own
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_cmd.op == OP_NONE) |-> m_axis_tlast)
        else $error("no-op command not marked last");

    // a clear is never the last command of its run (it is followed by two inverts)
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_cmd.op == OP_CLEAR) |-> !m_axis_tlast)
        else $error("clear command marked last");

    // only defined opcodes leave the block
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_cmd.op <= OP_NONE))
        else $error("undefined opcode issued");

    // a run is only popped when its head is present, and no push into a full queue comes with a pop
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid && !(push && queue_full))
        else $error("queue pop or push out of order");

endmodule
